/* sv/lfu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 5;
    localparam int CAPACITY_DEF = 16;
    localparam int CAP_RESET    = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } out_item_t;

    // scan results handed from the scanner to the update logic
    typedef struct packed {
        logic              found;
        logic              have_victim;
        logic              have_free;
        logic [DATA_W-1:0] found_data;
        logic [CNT_W-1:0]  found_count;
        logic [KEY_W-1:0]  victim_key;
    } scan_res_t;

endpackage

`default_nettype wire

/* sv/lfu_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

// One entry per step: key match, LFU/oldest victim compare, first free slot.
module lfu_scan #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       step,
    input  logic [IDX_W-1:0]           step_idx,
    input  logic                       ent_valid,
    input  logic [lfu_pkg::KEY_W-1:0]  ent_key,
    input  logic [lfu_pkg::DATA_W-1:0] ent_data,
    input  logic [lfu_pkg::CNT_W-1:0]  ent_count,
    input  logic [IDX_W-1:0]           ent_rank,
    input  logic [lfu_pkg::KEY_W-1:0]  req_key,
    output lfu_pkg::scan_res_t         res,
    output logic [IDX_W-1:0]           found_idx,
    output logic [IDX_W-1:0]           found_rank,
    output logic [IDX_W-1:0]           victim_idx,
    output logic [IDX_W-1:0]           victim_rank,
    output logic [IDX_W-1:0]           free_idx
);

    logic found_reg, found_next;
    logic victim_reg, victim_next;
    logic free_reg, free_next;

    logic [lfu_pkg::DATA_W-1:0] fdata_reg;
    logic [lfu_pkg::CNT_W-1:0]  fcount_reg;
    logic [lfu_pkg::CNT_W-1:0]  vcount_reg;
    logic [lfu_pkg::KEY_W-1:0]  vkey_reg;
    logic [IDX_W-1:0]           fidx_reg;
    logic [IDX_W-1:0]           frank_reg;
    logic [IDX_W-1:0]           vidx_reg;
    logic [IDX_W-1:0]           vrank_reg;
    logic [IDX_W-1:0]           free_idx_reg;

    logic take_found, take_victim, take_free;

    always_comb
    begin
        take_found  = step && ent_valid && !found_reg && (ent_key == req_key);
        take_victim = step && ent_valid &&
                      (!victim_reg || (ent_count < vcount_reg) ||
                       ((ent_count == vcount_reg) && (ent_rank > vrank_reg)));
        take_free   = step && !ent_valid && !free_reg;

        found_next  = clear ? 1'b0 : (found_reg || take_found);
        victim_next = clear ? 1'b0 : (victim_reg || take_victim);
        free_next   = clear ? 1'b0 : (free_reg || take_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            victim_reg <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            found_reg  <= found_next;
            victim_reg <= victim_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_found)
        begin
            fdata_reg  <= ent_data;
            fcount_reg <= ent_count;
            fidx_reg   <= step_idx;
            frank_reg  <= ent_rank;
        end
        if (take_victim)
        begin
            vcount_reg <= ent_count;
            vkey_reg   <= ent_key;
            vidx_reg   <= step_idx;
            vrank_reg  <= ent_rank;
        end
        if (take_free)
        begin
            free_idx_reg <= step_idx;
        end
    end

    assign res.found       = found_reg;
    assign res.have_victim = victim_reg;
    assign res.have_free   = free_reg;
    assign res.found_data  = fdata_reg;
    assign res.found_count = fcount_reg;
    assign res.victim_key  = vkey_reg;
    assign found_idx       = fidx_reg;
    assign found_rank      = frank_reg;
    assign victim_idx      = vidx_reg;
    assign victim_rank     = vrank_reg;
    assign free_idx        = free_idx_reg;

endmodule

`default_nettype wire

/* sv/lfu_cache_replacement_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LFU key/value cache with CAPACITY slots. Each input item
// is a get or a set; each gives exactly one result item (hit, read value,
// eviction flag and evicted key). A hit bumps the entry's use count
// (saturating at 65535) and makes it the newest; a set miss fills a free slot
// or, once the configured capacity is reached, evicts the lowest count entry,
// oldest first among equal counts. Capacity is written through the cfg port
// (reset 16, clamped to CAPACITY, zero turns every set into a no-op) and
// must only be changed while no item is in flight. An item is worked in
// order: the entry memory is read one slot per cycle through its single
// registered read port, the last slot read is compared, and an update step
// loads the result register. The sequencer then returns to idle, and only
// there is a new item accepted. in_stall is high for the whole time an
// item is in work. The result sits in an output register, so a new item is
// accepted while an earlier result still waits; its update cycle is held off
// until that earlier result has been taken.
module lfu_cache_replacement_unit #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  lfu_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lfu_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0] cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CW    = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;
    localparam int KW    = lfu_pkg::KEY_W;
    localparam int DW    = lfu_pkg::DATA_W;
    localparam int NW    = lfu_pkg::CNT_W;
    localparam int ROW_W = KW + DW + NW;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [OCC_W-1:0] cnt_reg, cnt_next;       // next slot to read
    logic rd_vld_reg, rd_vld_next;             // read data valid this cycle
    logic [IDX_W-1:0] rd_idx_reg;
    logic [ROW_W-1:0] rd_row_reg;

    logic [lfu_pkg::CFG_W-1:0] cap_reg, cap_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic out_valid_reg, out_valid_next;
    lfu_pkg::out_item_t out_reg, out_next;
    lfu_pkg::in_item_t item_reg;

    // entry state: valid bits and age ranks live in flops, one cell per slot,
    // key/data/count live in the row memory
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]    rank_reg  [CAPACITY];
    logic [IDX_W-1:0]    rank_next [CAPACITY];
    logic [ROW_W-1:0]    mem [CAPACITY];

    logic accept, issue, done_fire;

    lfu_pkg::scan_res_t res;
    logic [IDX_W-1:0] found_idx, found_rank, victim_idx, victim_rank, free_idx;

    logic             is_set, cap_zero, full, do_bump, do_fill, evict, wr_en;
    logic [CW-1:0]    cap_lim;
    logic [IDX_W-1:0] fill_idx, wr_idx;
    logic [NW-1:0]    cnt_inc;
    logic [ROW_W-1:0] wr_row;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg != OCC_W'(CAPACITY));
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_vld_next = issue;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + OCC_W'(1);
                end
                // last slot is compared in the cycle after its read
                if (!issue && rd_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- row memory ----------------
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_row_reg <= mem[cnt_reg[IDX_W-1:0]];
            rd_idx_reg <= cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_row;
        end
    end

    // ---------------- scan unit ----------------
    lfu_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .step        (rd_vld_reg),
        .step_idx    (rd_idx_reg),
        .ent_valid   (valid_reg[rd_idx_reg]),
        .ent_key     (rd_row_reg[ROW_W-1 -: KW]),
        .ent_data    (rd_row_reg[NW +: DW]),
        .ent_count   (rd_row_reg[NW-1:0]),
        .ent_rank    (rank_reg[rd_idx_reg]),
        .req_key     (item_reg.key),
        .res         (res),
        .found_idx   (found_idx),
        .found_rank  (found_rank),
        .victim_idx  (victim_idx),
        .victim_rank (victim_rank),
        .free_idx    (free_idx)
    );

    // ---------------- update decision ----------------
    always_comb
    begin
        is_set   = (item_reg.func == lfu_pkg::FUNC_SET);
        cap_zero = (cap_reg == '0);
        cap_lim  = (CW'(cap_reg) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_reg);
        full     = (CW'(occ_reg) >= cap_lim);

        // a set with capacity zero leaves everything alone, even on a hit
        do_bump  = res.found && (!is_set || !cap_zero);
        do_fill  = is_set && !cap_zero && !res.found;
        evict    = do_fill && full && res.have_victim;

        // the freed victim slot competes with the lowest free slot
        if (evict && !(res.have_free && (free_idx < victim_idx)))
        begin
            fill_idx = victim_idx;
        end
        else
        begin
            fill_idx = free_idx;
        end

        cnt_inc = (res.found_count == lfu_pkg::COUNT_MAX) ? res.found_count
                                                         : res.found_count + NW'(1);

        wr_en  = done_fire && (do_bump || do_fill);
        wr_idx = do_bump ? found_idx : fill_idx;
        if (do_bump)
        begin
            wr_row = {item_reg.key,
                      (is_set ? item_reg.value : DW'(res.found_data)), cnt_inc};
        end
        else
        begin
            wr_row = {item_reg.key, item_reg.value, NW'(1)};
        end
    end

    // per-slot age update: touch on a hit, drop+fill or plain fill on a miss
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        if (done_fire)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (do_bump)
                begin
                    if (valid_reg[i] && (IDX_W'(i) != found_idx) &&
                        (rank_reg[i] < found_rank))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                else if (do_fill)
                begin
                    if (valid_reg[i] && !(evict && (IDX_W'(i) == victim_idx)) &&
                        !(evict && (rank_reg[i] > victim_rank)))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
            if (do_bump)
            begin
                rank_next[found_idx] = '0;
            end
            if (do_fill)
            begin
                if (evict)
                begin
                    valid_next[victim_idx] = 1'b0;
                end
                else
                begin
                    occ_next = occ_reg + OCC_W'(1);
                end
                valid_next[fill_idx] = 1'b1;
                rank_next[fill_idx]  = '0;
            end
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (done_fire)
        begin
            out_valid_next         = 1'b1;
            out_next.hit           = res.found;
            out_next.read_value    = (!is_set && res.found) ? DW'(res.found_data) : '0;
            out_next.evicted       = evict;
            out_next.evicted_key   = evict ? KW'(res.victim_key) : '0;
        end
    end

    assign cap_next = cfg_valid ? cfg_data : cap_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            cap_reg       <= lfu_pkg::CFG_W'(lfu_pkg::CAP_RESET);
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        out_reg  <= out_next;
        rank_reg <= rank_next;
    end

    // ---------------- checks ----------------
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count out of step with valid bits");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= CAPACITY)
        else $error("occupancy above slot count");

    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.evicted && out_reg.hit))
        else $error("eviction reported on a hit");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (cnt_reg == OCC_W'(CAPACITY)) && !rd_vld_reg)
        else $error("update reached before scan finished");

    a_miss_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.hit) |-> (out_reg.read_value == '0))
        else $error("read value on a miss");

endmodule

`default_nettype wire
